>>> hw/rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

  // Operation codes on in_operation
  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam int unsigned PRIO_W = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 5;

  // One stored entry
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } entry_t;

  // Command broadcast to every cell in the chain
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t item;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/sorted_priority_queue.sv
// Sorted priority queue of QUEUE_DEPTH (priority, data) entries held in a row
// of cells in ascending priority order, head in cell 0. Each cell compares its
// priority with the incoming one in parallel, so an enqueue (inserted behind
// equal priorities) or a dequeue of the head updates all cells at once. One
// word is taken per clock whenever the result register is empty or being read;
// the result appears in the cycle after acceptance. Enqueue on a full queue
// reports status full, dequeue on an empty queue reports status empty with
// zero priority and data; occupancy is the count after the operation, mod 32.
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_operation,
  input  wire logic [15:0]         in_item_priority,
  input  wire logic signed [31:0]  in_item_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_status,
  output logic [15:0]              out_priority,
  output logic signed [31:0]       out_data,
  output logic [4:0]               out_occupancy
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic                  accept;
  logic                  full;
  logic                  empty;
  spq_pkg::cell_ctrl_t   ctrl;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic [CW+4:0]         count_ext;
  spq_pkg::status_t      status_nxt;
  spq_pkg::entry_t       head_nxt;
  spq_pkg::entry_t       cell_entry [QUEUE_DEPTH];
  logic                  cell_gt    [QUEUE_DEPTH];

  logic                  out_valid_r;
  spq_pkg::status_t      out_status_r;
  spq_pkg::entry_t       out_entry_r;
  logic [4:0]            out_occupancy_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);

  // Broadcast the command to the chain
  always_comb begin
    ctrl.enq       = accept && (in_operation == spq_pkg::OP_ENQ) && !full;
    ctrl.deq       = accept && (in_operation == spq_pkg::OP_DEQ) && !empty;
    ctrl.item.prio = in_item_priority;
    ctrl.item.data = in_item_data;
  end

  // Build the chain of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic            occ;
    logic            lgt;
    spq_pkg::entry_t lent;
    spq_pkg::entry_t rent;

    assign occ = (count_r > CW'(i));

    if (i == 0) begin : g_first
      assign lgt  = 1'b0;
      assign lent = ctrl.item;
    end else begin : g_mid
      assign lgt  = cell_gt[i-1];
      assign lent = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign rent = cell_entry[i];
    end else begin : g_inner
      assign rent = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occ),
      .left_gt     (lgt),
      .left_entry  (lent),
      .right_entry (rent),
      .gt          (cell_gt[i]),
      .entry       (cell_entry[i])
    );
  end

  // Work out count and result for the accepted word
  always_comb begin
    count_nxt  = count_r;
    status_nxt = spq_pkg::ST_OK;
    head_nxt   = '0;
    if (in_operation == spq_pkg::OP_ENQ) begin
      if (full) begin
        status_nxt = spq_pkg::ST_FULL;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else begin
        count_nxt = count_r - CW'(1);
        head_nxt  = cell_entry[0];
      end
    end
  end

  assign count_ext = {5'd0, count_nxt};

  // Advance the entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r    <= status_nxt;
      out_entry_r     <= head_nxt;
      out_occupancy_r <= count_ext[4:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_priority  = out_entry_r.prio;
  assign out_data      = out_entry_r.data;
  assign out_occupancy = out_occupancy_r;

endmodule

`default_nettype wire

>>> hw/rtl/spq_cell.sv
`default_nettype none

module spq_cell (
  input  wire logic               clk,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire logic               occupied,
  input  wire logic               left_gt,
  input  wire spq_pkg::entry_t    left_entry,
  input  wire spq_pkg::entry_t    right_entry,
  output logic                    gt,
  output spq_pkg::entry_t         entry
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // Flag cells that sit behind the insertion point
  assign gt = !occupied || (entry_r.prio > ctrl.item.prio);

  // Pick insert, shift up, shift down or hold
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.enq && gt) begin
      entry_nxt = left_gt ? left_entry : ctrl.item;
    end else if (ctrl.deq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

>>> hw/rtl/spq_checker.sv
`default_nettype none

module spq_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         out_status,
  input wire logic [15:0]        out_priority,
  input wire logic signed [31:0] out_data,
  input wire logic [4:0]         out_occupancy
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_priority) && $stable(out_data) && $stable(out_occupancy))
    else $error("result word changed while stalled");

  // Every accepted word yields a result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  // Refused enqueue only when full
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spq_pkg::ST_FULL |->
      out_occupancy == 5'(QUEUE_DEPTH) && out_priority == '0 && out_data == '0)
    else $error("full status with wrong occupancy or payload");

  // Empty dequeue reports zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spq_pkg::ST_EMPTY |->
      out_occupancy == '0 && out_priority == '0 && out_data == '0)
    else $error("empty status with nonzero fields");

endmodule

bind sorted_priority_queue spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_priority  (out_priority),
  .out_data      (out_data),
  .out_occupancy (out_occupancy)
);

`default_nettype wire
